FILE: rtl/thv_pkg.sv
package thv_pkg;

  // Header fields as they arrive, already split out of the 16-byte header
  typedef struct packed {
    logic [31:0] file_size;
    logic [15:0] header_gate;
    logic [31:0] format_word;
    logic [7:0]  width_log2;
    logic [7:0]  height_log2;
    logic [7:0]  mip_count;
    logic [15:0] shown_width;
    logic [15:0] shown_height;
  } thv_in_t;

  // Decoded result; every field but accepted is zero on reject
  typedef struct packed {
    logic        accepted;
    logic [15:0] raw_width;
    logic [15:0] raw_height;
    logic [15:0] apparent_width;
    logic [15:0] apparent_height;
    logic [15:0] type_pair;
    logic [7:0]  number_format;
    logic [63:0] channel_map;
  } thv_out_t;

  localparam logic [15:0] HDR_GATE     = 16'h0004;
  localparam logic [31:0] MIN_SIZE     = 32'h0000_0011;
  localparam logic [31:0] SIZE_BIAS    = 32'h0000_0010;
  localparam logic [31:0] TYPE_MASK    = 32'h0000_0f00;
  localparam int          TYPE_LSB     = 8;

  localparam logic [3:0]  TYPE_PLAIN   = 4'd1;
  localparam logic [3:0]  TYPE_WORD    = 4'd2;
  localparam logic [3:0]  TYPE_DWORD   = 4'd3;

  // Layout sets of the plain type, one bit per layout code
  localparam logic [15:0] BPP16_MASK   = 16'h08b8;
  localparam logic [15:0] BPP24_MASK   = 16'h0042;
  localparam logic [15:0] BPP32_MASK   = 16'h0204;

  localparam logic [5:0]  BPP_2        = 6'd2;
  localparam logic [5:0]  BPP_4        = 6'd4;
  localparam logic [5:0]  BPP_16       = 6'd16;
  localparam logic [5:0]  BPP_24       = 6'd24;
  localparam logic [5:0]  BPP_32       = 6'd32;

  localparam logic [7:0]  NFMT_NONE    = 8'h00;
  localparam logic [7:0]  NFMT_SHORT   = 8'h10;
  localparam logic [7:0]  NFMT_FLOAT   = 8'h30;

  function automatic logic [5:0] bits_per_pixel(input logic [3:0] type_nib,
                                                input logic [3:0] lay);
    logic [5:0] bpp;
    bpp = BPP_2;
    unique case (type_nib)
      TYPE_WORD:  bpp = BPP_2;
      TYPE_DWORD: bpp = BPP_4;
      TYPE_PLAIN: begin
        if (BPP16_MASK[lay])      bpp = BPP_16;
        else if (BPP24_MASK[lay]) bpp = BPP_24;
        else if (BPP32_MASK[lay]) bpp = BPP_32;
        else                      bpp = BPP_2;
      end
      default:    bpp = BPP_2;
    endcase
    return bpp;
  endfunction

  function automatic logic [15:0] type_pair_of(input logic [3:0] type_nib);
    logic [15:0] tp;
    unique case (type_nib)
      TYPE_WORD:  tp = 16'h0202;
      TYPE_DWORD: tp = 16'h0402;
      4'd4:       tp = 16'h5304;
      4'd5:       tp = 16'h3504;
      4'd6:       tp = 16'h0804;
      4'd7:       tp = 16'h0404;
      4'd8:       tp = 16'h0204;
      default:    tp = 16'h0000;
    endcase
    return tp;
  endfunction

  function automatic logic [7:0] number_format_of(input logic [3:0] lay);
    logic [7:0] nf;
    case (lay) inside
      4'd2, 4'd8, 4'd9:                     nf = NFMT_FLOAT;
      4'd3, 4'd4, 4'd5, 4'd7, 4'd10, 4'd11: nf = NFMT_SHORT;
      default:                              nf = NFMT_NONE;
    endcase
    return nf;
  endfunction

  // Channel bytes per layout, first byte in bits 7:0
  function automatic logic [63:0] channel_map_of(input logic [3:0] lay);
    logic [63:0] cm;
    unique case (lay)
      4'd1:    cm = 64'h0000_0408_0308_0208;
      4'd2:    cm = 64'h0208_0308_0408_0108;
      4'd3:    cm = 64'h0101_0405_0305_0205;
      4'd4:    cm = 64'h0104_0404_0304_0204;
      4'd5:    cm = 64'h0000_0405_0306_0205;
      4'd6:    cm = 64'h0000_0208_0308_0408;
      4'd7:    cm = 64'h0405_0305_0205_0101;
      4'd8:    cm = 64'h0408_0308_0208_0108;
      4'd9:    cm = 64'h0408_0308_0208_0008;
      4'd10:   cm = 64'h0001_0405_0305_0205;
      4'd11:   cm = 64'h0404_0304_0204_0104;
      default: cm = 64'h0000_0000_0000_0000;
    endcase
    return cm;
  endfunction

endpackage

FILE: rtl/texture_header_validator.sv
// Channel   Ports              Dir  Beat taken when
// -------   -----------------  ---  ------------------------------------
// header    start, busy, hdr   in   rising edge with start high, busy low
// result    done, result       out  rising edge ending the cycle done is high
//
// Fully pipelined: one header beat may enter every cycle; busy stays low.
// Pipeline stages from the accepting edge to the done cycle: one decode
// stage, one stage per mip level (MAX_LOG2 + 1 of them, each adding one
// level's byte count), and the result register.
// rst (synchronous) clears every valid bit; payload registers are not reset.
// The receiver cannot stall, so nothing ever holds the pipeline.
module texture_header_validator
  import thv_pkg::*;
#(
  parameter int MAX_LOG2 = 15
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  thv_in_t  hdr,
  output logic     done,
  output thv_out_t result
);

  // Number of mip stages; the mip count may not exceed max log2 + 1
  localparam int NST = MAX_LOG2 + 1;
  localparam int L2W = $clog2(MAX_LOG2 + 1);

  typedef struct packed {
    logic           ok;
    logic [31:0]    file_size;
    logic [L2W-1:0] wl;
    logic [L2W-1:0] hl;
    logic [7:0]     mips;
    logic [5:0]     bpp;
    logic [3:0]     type_nib;
    logic [3:0]     lay;
    logic [15:0]    shown_width;
    logic [15:0]    shown_height;
    logic [31:0]    total;
  } stage_t;

  logic   vld [NST+1];
  stage_t stg [NST+1];

  // Never hold off a header beat: every stage advances every cycle
  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // Decode stage: run all the checks that do not need the chain total.
  // ---------------------------------------------------------------------
  logic       take;
  logic [3:0] type_nib;
  logic [3:0] lay;
  logic [8:0] max_mips;
  logic       logs_ok;
  logic       type_ok;
  stage_t     dec;

  assign take = start && !busy;

  always_comb begin
    type_nib = 4'((hdr.format_word & TYPE_MASK) >> TYPE_LSB);
    lay      = hdr.format_word[3:0];
    // Compare log2 against the limit at full width before narrowing
    logs_ok  = (hdr.width_log2 <= 8'(MAX_LOG2)) && (hdr.height_log2 <= 8'(MAX_LOG2));
    max_mips = (hdr.width_log2 < hdr.height_log2) ? {1'b0, hdr.height_log2} + 9'd1
                                                  : {1'b0, hdr.width_log2} + 9'd1;
    type_ok  = (type_nib == TYPE_PLAIN) || (type_nib == TYPE_WORD) ||
               (type_nib == TYPE_DWORD);

    dec.ok           = (hdr.file_size >= MIN_SIZE) && (hdr.header_gate == HDR_GATE) &&
                       logs_ok && ({1'b0, hdr.mip_count} <= max_mips) && type_ok;
    dec.file_size    = hdr.file_size;
    dec.wl           = hdr.width_log2[L2W-1:0];
    dec.hl           = hdr.height_log2[L2W-1:0];
    dec.mips         = hdr.mip_count;
    dec.bpp          = bits_per_pixel(type_nib, lay);
    dec.type_nib     = type_nib;
    dec.lay          = lay;
    dec.shown_width  = hdr.shown_width;
    dec.shown_height = hdr.shown_height;
    dec.total        = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= take;
    end
    stg[0] <= dec;
  end

  // ---------------------------------------------------------------------
  // Mip stages: stage k adds level k when k is below the mip count.
  // Level size is a power of two, so bpp * area is a shift of bpp; keep
  // the low 32 bits of that product, drop three bits to get bytes.
  // ---------------------------------------------------------------------
  for (genvar k = 0; k < NST; k++) begin : g_mip
    logic [L2W-1:0] wk;
    logic [L2W-1:0] hk;
    logic [L2W:0]   sk;
    logic [63:0]    prod;
    stage_t         nxt;

    always_comb begin
      // Each side halves until it reaches one
      wk   = (stg[k].wl > L2W'(k)) ? stg[k].wl - L2W'(k) : '0;
      hk   = (stg[k].hl > L2W'(k)) ? stg[k].hl - L2W'(k) : '0;
      sk   = {1'b0, wk} + {1'b0, hk};
      prod = {58'd0, stg[k].bpp} << sk;
      nxt  = stg[k];
      if (8'(k) < stg[k].mips) begin
        nxt.total = stg[k].total + {3'b000, prod[31:3]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      stg[k+1] <= nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result stage: final size check, then drive the decoded beat or zeros.
  // ---------------------------------------------------------------------
  stage_t   fin;
  logic     pass;
  thv_out_t res_next;
  logic [31:0] wide_w;
  logic [31:0] wide_h;

  always_comb begin
    fin      = stg[NST];
    pass     = fin.ok && ((fin.total + SIZE_BIAS) == fin.file_size);
    wide_w   = 32'd1 << fin.wl;
    wide_h   = 32'd1 << fin.hl;
    res_next = '0;
    if (pass) begin
      res_next.accepted        = 1'b1;
      res_next.raw_width       = wide_w[15:0];
      res_next.raw_height      = wide_h[15:0];
      res_next.apparent_width  = fin.shown_width;
      res_next.apparent_height = fin.shown_height;
      res_next.type_pair       = type_pair_of(fin.type_nib);
      res_next.number_format   = number_format_of(fin.lay);
      res_next.channel_map     = channel_map_of(fin.lay);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[NST];
    end
    // Hold the last result between strobes; update only on a live beat
    if (vld[NST]) begin
      result <= res_next;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Every accepted header produces its strobe after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    take |-> ##(NST + 2) done)
    else $error("header beat did not produce a result beat on time");

  // A rejected header drives all decoded fields to zero
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.accepted) |->
      (result.raw_width == 16'd0 && result.raw_height == 16'd0 &&
       result.apparent_width == 16'd0 && result.apparent_height == 16'd0 &&
       result.type_pair == 16'd0 && result.number_format == 8'd0 &&
       result.channel_map == 64'd0))
    else $error("rejected result carries nonzero fields");

  // Only the three accepted types can reach an accepted result
  a_type_pair: assert property (@(posedge clk) disable iff (rst)
    (done && result.accepted) |->
      (result.type_pair == 16'h0000 || result.type_pair == 16'h0202 ||
       result.type_pair == 16'h0402))
    else $error("accepted result with a type pair of a rejected type");

endmodule

FILE: bench/thv_checker.sv
module thv_checker
  import thv_pkg::*;
#(
  parameter int MAX_LOG2 = 15
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  thv_in_t  hdr,
  input  logic     done,
  input  thv_out_t result,
  output int       mismatches,
  output int       pending
);

  thv_out_t pending_decodes[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  // First channel byte goes to bits 7:0
  function automatic logic [63:0] bytes_lsb_first(input logic [7:0] b0, b1, b2, b3,
                                                  input logic [7:0] b4, b5, b6, b7);
    return {b7, b6, b5, b4, b3, b2, b1, b0};
  endfunction

  function automatic logic [63:0] channel_row(input logic [3:0] lay);
    logic [63:0] row;
    case (lay)
      4'd1:    row = bytes_lsb_first(8, 2, 8, 3, 8, 4, 0, 0);
      4'd2:    row = bytes_lsb_first(8, 1, 8, 4, 8, 3, 8, 2);
      4'd3:    row = bytes_lsb_first(5, 2, 5, 3, 5, 4, 1, 1);
      4'd4:    row = bytes_lsb_first(4, 2, 4, 3, 4, 4, 4, 1);
      4'd5:    row = bytes_lsb_first(5, 2, 6, 3, 5, 4, 0, 0);
      4'd6:    row = bytes_lsb_first(8, 4, 8, 3, 8, 2, 0, 0);
      4'd7:    row = bytes_lsb_first(1, 1, 5, 2, 5, 3, 5, 4);
      4'd8:    row = bytes_lsb_first(8, 1, 8, 2, 8, 3, 8, 4);
      4'd9:    row = bytes_lsb_first(8, 0, 8, 2, 8, 3, 8, 4);
      4'd10:   row = bytes_lsb_first(5, 2, 5, 3, 5, 4, 1, 0);
      4'd11:   row = bytes_lsb_first(4, 1, 4, 2, 4, 3, 4, 4);
      default: row = '0;
    endcase
    return row;
  endfunction

  // Number type per layout; 0 means none
  function automatic logic [7:0] layout_numtype(input logic [3:0] lay);
    logic [7:0] nt;
    case (lay)
      4'd1, 4'd6:                           nt = 8'd1;
      4'd3, 4'd4, 4'd5, 4'd7, 4'd10, 4'd11: nt = 8'd2;
      4'd2, 4'd8, 4'd9:                     nt = 8'd4;
      default:                              nt = 8'd0;
    endcase
    return nt;
  endfunction

  function automatic logic [31:0] plain_bpp(input logic [3:0] lay);
    logic [31:0] bpp;
    case (lay)
      4'd3, 4'd4, 4'd5, 4'd7, 4'd11: bpp = 32'd16;
      4'd1, 4'd6:                    bpp = 32'd24;
      4'd2, 4'd9:                    bpp = 32'd32;
      default:                       bpp = 32'd2;
    endcase
    return bpp;
  endfunction

  function automatic thv_out_t decode_header(input thv_in_t h);
    thv_out_t    r;
    logic [3:0]  kind;
    logic [3:0]  lay;
    logic [8:0]  level_limit;
    logic [31:0] bpp;
    logic [31:0] w;
    logic [31:0] ht;
    logic [31:0] area;
    logic [31:0] total;
    logic [63:0] prod;
    logic [7:0]  nt;
    int          m;
    r    = '0;
    kind = h.format_word[11:8];
    lay  = h.format_word[3:0];
    if (h.file_size < 32'd17 || h.header_gate != 16'd4) return r;
    if (h.width_log2 > MAX_LOG2 || h.height_log2 > MAX_LOG2) return r;
    level_limit = 9'(h.width_log2 > h.height_log2 ? h.width_log2 : h.height_log2) + 9'd1;
    if (level_limit < 9'(h.mip_count)) return r;
    if (kind == TYPE_WORD)       bpp = 32'd2;
    else if (kind == TYPE_DWORD) bpp = 32'd4;
    else if (kind == TYPE_PLAIN) bpp = plain_bpp(lay);
    else return r;

    w     = 32'd1 << h.width_log2;
    ht    = 32'd1 << h.height_log2;
    total = '0;
    for (m = 0; m < int'(h.mip_count); m++) begin
      area  = w * ht;
      prod  = {32'd0, bpp} * {32'd0, area};
      total = total + {3'd0, prod[31:3]};
      if (w > 32'd1) w = w >> 1;
      if (ht > 32'd1) ht = ht >> 1;
    end
    if (total + 32'd16 != h.file_size) return r;

    r.accepted        = 1'b1;
    r.raw_width       = 16'(32'd1 << h.width_log2);
    r.raw_height      = 16'(32'd1 << h.height_log2);
    r.apparent_width  = h.shown_width;
    r.apparent_height = h.shown_height;
    if (kind == TYPE_WORD)       r.type_pair = 16'h0202;
    else if (kind == TYPE_DWORD) r.type_pair = 16'h0402;
    nt = layout_numtype(lay);
    if (nt != 8'd0) r.number_format = (nt - 8'd1) * 8'h10;
    r.channel_map = channel_row(lay);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    thv_out_t want;
    if (!rst) begin
      if (done) begin
        if (pending_decodes.size() == 0) begin
          report_mismatch("unexpected result beat", 64'(result.accepted), '0);
        end else begin
          want = pending_decodes.pop_front();
          if (result.accepted !== want.accepted)
            report_mismatch("accepted", 64'(result.accepted), 64'(want.accepted));
          if (result.raw_width !== want.raw_width)
            report_mismatch("raw_width", 64'(result.raw_width), 64'(want.raw_width));
          if (result.raw_height !== want.raw_height)
            report_mismatch("raw_height", 64'(result.raw_height), 64'(want.raw_height));
          if (result.apparent_width !== want.apparent_width)
            report_mismatch("apparent_width", 64'(result.apparent_width),
                            64'(want.apparent_width));
          if (result.apparent_height !== want.apparent_height)
            report_mismatch("apparent_height", 64'(result.apparent_height),
                            64'(want.apparent_height));
          if (result.type_pair !== want.type_pair)
            report_mismatch("type_pair", 64'(result.type_pair), 64'(want.type_pair));
          if (result.number_format !== want.number_format)
            report_mismatch("number_format", 64'(result.number_format),
                            64'(want.number_format));
          if (result.channel_map !== want.channel_map)
            report_mismatch("channel_map", result.channel_map, want.channel_map);
        end
      end
      if (start && !busy) pending_decodes.push_back(decode_header(hdr));
    end
    pending = pending_decodes.size();
  end

endmodule

FILE: bench/tb_texture_header_validator.sv
module tb_texture_header_validator
  import thv_pkg::*;
;

  localparam int MAX_LOG2       = 15;
  // Accepting edge to done cycle
  localparam int LATENCY        = MAX_LOG2 + 3;
  localparam int RANDOM_HEADERS = 1600;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  thv_in_t  hdr;
  logic     done;
  thv_out_t result;
  int       mismatches;
  int       pending;
  // Chance in percent that the sender holds off before a beat
  int       idle_pct;

  texture_header_validator #(.MAX_LOG2(MAX_LOG2)) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .hdr    (hdr),
    .done   (done),
    .result (result)
  );

  // Watches both channels, predicts every header and compares each result beat
  thv_checker #(.MAX_LOG2(MAX_LOG2)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .hdr        (hdr),
    .done       (done),
    .result     (result),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Hard stop in case the block hangs; far beyond the slowest correct run
  initial begin
    #(12 * 400000);
    $display("TEST FAILED");
    $finish;
  end

  // File size that makes the mip chain of h add up exactly. Only shapes the
  // stimulus so that most headers get through every check; the checker
  // decides on its own what the block must answer.
  function automatic logic [31:0] matching_file_size(input thv_in_t h);
    logic [3:0]  kind;
    logic [3:0]  lay;
    logic [31:0] bpp;
    logic [31:0] w;
    logic [31:0] ht;
    logic [31:0] area;
    logic [31:0] total;
    logic [63:0] prod;
    int          m;
    kind = h.format_word[11:8];
    lay  = h.format_word[3:0];
    if (kind == TYPE_WORD)       bpp = 32'(BPP_2);
    else if (kind == TYPE_DWORD) bpp = 32'(BPP_4);
    else if (BPP16_MASK[lay])    bpp = 32'(BPP_16);
    else if (BPP24_MASK[lay])    bpp = 32'(BPP_24);
    else if (BPP32_MASK[lay])    bpp = 32'(BPP_32);
    else                         bpp = 32'(BPP_2);
    w     = 32'd1 << h.width_log2;
    ht    = 32'd1 << h.height_log2;
    total = '0;
    for (m = 0; m < int'(h.mip_count); m++) begin
      area  = w * ht;
      prod  = {32'd0, bpp} * {32'd0, area};
      total = total + {3'd0, prod[31:3]};
      w     = (w > 32'd1) ? w >> 1 : w;
      ht    = (ht > 32'd1) ? ht >> 1 : ht;
    end
    return total + SIZE_BIAS;
  endfunction

  // Header with chosen type, layout and sizes; random everywhere else,
  // file size fitted to the chain
  function automatic thv_in_t sized_header(input logic [3:0] kind, input logic [3:0] lay,
                                           input logic [7:0] wl, input logic [7:0] hl,
                                           input logic [7:0] mips);
    thv_in_t h;
    h.header_gate      = HDR_GATE;
    h.format_word      = $urandom();
    h.format_word[11:8] = kind;
    h.format_word[3:0] = lay;
    h.width_log2       = wl;
    h.height_log2      = hl;
    h.mip_count        = mips;
    h.shown_width      = 16'($urandom());
    h.shown_height     = 16'($urandom());
    h.file_size        = matching_file_size(h);
    return h;
  endfunction

  // Legal header with random content; the plain type gets half the weight
  // since it alone spreads over all layouts
  function automatic thv_in_t well_formed_header();
    logic [3:0] kind;
    logic [7:0] wl;
    logic [7:0] hl;
    logic [7:0] top_log2;
    case ($urandom_range(3))
      0:       kind = TYPE_WORD;
      1:       kind = TYPE_DWORD;
      default: kind = TYPE_PLAIN;
    endcase
    wl       = 8'($urandom_range(MAX_LOG2));
    hl       = 8'($urandom_range(MAX_LOG2));
    top_log2 = (wl > hl) ? wl : hl;
    return sized_header(kind, 4'($urandom()), wl, hl,
                        8'($urandom_range(int'(top_log2) + 1, 1)));
  endfunction

  // Present one header beat, idling first at the current rate, and hold it
  // until the block takes it. start stays high into the next beat unless an
  // idle cycle follows, so it is never dropped and raised at one edge.
  task automatic send_header(input thv_in_t h);
    while (int'($urandom_range(99)) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    hdr   <= h;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    thv_in_t h;
    int      i;
    int      pick;
    int      waited;
    rst      = 1'b1;
    start    = 1'b0;
    hdr      = '0;
    idle_pct = 17;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed beats

    // Smallest image in two bits per pixel: the chain rounds to zero bytes,
    // so the only matching size is too short
    send_header(sized_header(TYPE_PLAIN, 4'd0, 8'd0, 8'd0, 8'd1));

    // Every layout code of the plain type, unlisted ones included
    for (i = 0; i < 16; i++)
      send_header(sized_header(TYPE_PLAIN, 4'(i), 8'd3, 8'd5, 8'($urandom_range(6, 1))));

    // Largest sizes and full chains for the two fixed-depth types
    send_header(sized_header(TYPE_WORD, 4'($urandom()), 8'd15, 8'd0, 8'd16));
    send_header(sized_header(TYPE_DWORD, 4'($urandom()), 8'd0, 8'd15, 8'd16));

    // Full 32-bit layout at the top size: the chain total wraps
    h = sized_header(TYPE_PLAIN, 4'd2, 8'd15, 8'd15, 8'd16);
    h.shown_width  = 16'hffff;
    h.shown_height = 16'hffff;
    send_header(h);

    // Zero mips: chain total is zero, size 16 is short and 17 does not match
    h = sized_header(TYPE_PLAIN, 4'd4, 8'd4, 8'd4, 8'd0);
    h.shown_width  = 16'h0000;
    h.shown_height = 16'h0000;
    send_header(h);
    h.file_size = MIN_SIZE;
    send_header(h);

    // Wrong gate word
    h = well_formed_header();
    h.header_gate = 16'hffff;
    send_header(h);
    h.header_gate = 16'h0005;
    send_header(h);

    // Log2 just above the limit and at the field maximum
    send_header(sized_header(TYPE_PLAIN, 4'd3, 8'd16, 8'd2, 8'd1));
    send_header(sized_header(TYPE_WORD, 4'd0, 8'd1, 8'd255, 8'd1));

    // One mip too many, then the field maximum
    h = sized_header(TYPE_DWORD, 4'd5, 8'd6, 8'd3, 8'd8);
    send_header(h);
    h.mip_count = 8'hff;
    h.file_size = matching_file_size(h);
    send_header(h);

    // Unknown type nibbles at both ends
    send_header(sized_header(4'd0, 4'd1, 8'd2, 8'd2, 8'd2));
    send_header(sized_header(4'd15, 4'd1, 8'd2, 8'd2, 8'd2));

    // Random beats: mostly legal headers, the rest near misses and noise
    for (i = 0; i < RANDOM_HEADERS; i++) begin
      if (i == RANDOM_HEADERS / 3) idle_pct = 57;
      if (i == 2 * RANDOM_HEADERS / 3) idle_pct = 0;
      pick = $urandom_range(19);
      h    = well_formed_header();
      if (pick == 14) begin
        // Size off by one either way
        h.file_size = $urandom_range(1) ? h.file_size + 32'd1 : h.file_size - 32'd1;
      end else if (pick == 15) begin
        h.file_size = h.file_size ^ (32'd1 << $urandom_range(31));
      end else if (pick == 16) begin
        h.header_gate = 16'($urandom());
      end else if (pick == 17) begin
        // Log2 or mip count anywhere in the field; refit so nothing else fails
        case ($urandom_range(2))
          0:       h.width_log2 = 8'($urandom());
          1:       h.height_log2 = 8'($urandom());
          default: h.mip_count = 8'($urandom());
        endcase
        h.file_size = matching_file_size(h);
      end else if (pick == 18) begin
        h.format_word[11:8] = 4'($urandom());
        h.file_size = matching_file_size(h);
      end else if (pick == 19) begin
        h.file_size    = $urandom();
        h.header_gate  = 16'($urandom());
        h.format_word  = $urandom();
        h.width_log2   = 8'($urandom());
        h.height_log2  = 8'($urandom());
        h.mip_count    = 8'($urandom());
      end
      send_header(h);
    end
    start <= 1'b0;

    // Drain: wait for the last results, then a quiet stretch to catch extras
    waited = 0;
    while (pending != 0 && waited < 4 * LATENCY + 100) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 4) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/thv_pkg.sv
rtl/texture_header_validator.sv
bench/thv_checker.sv
bench/tb_texture_header_validator.sv
